// ===== src/fcmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO cache miss counter package
// Shared types and constants: word width, presence epoch width, register map
// and the packed transaction payloads of both channels.
// ----------------------------------------------------------------------------
package fcmc_pkg;

  localparam int unsigned WORD_BITS  = 10;
  localparam int unsigned WORD_COUNT = 1 << WORD_BITS;
  localparam int unsigned EPOCH_BITS = 8;
  localparam int unsigned MISS_BITS  = 32;
  localparam int unsigned CAP_BITS   = 8;
  localparam int unsigned PADDR_BITS = 3;
  localparam int unsigned PDATA_BITS = 32;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;
  typedef logic [0:0]            reg_idx_t;

  localparam reg_idx_t REG_CAPACITY = 1'b0;

  typedef struct packed {
    word_t word;
    logic  last;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    word_t                evicted_word;
    logic [MISS_BITS-1:0] miss_count;
    logic                 done_res;
  } out_t;

endpackage

// ===== src/fcmc_sdp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO cache miss counter simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcmc_sdp_ram #(
  parameter int unsigned WIDTH     = 10,
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fifo_cache_miss_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO cache miss counter
// Looks up each word in a cache with first-in-first-out replacement, reports
// hits, evictions and a saturating per-sequence miss count.
// ----------------------------------------------------------------------------
// Each transaction passes through three states: accept issues reads of the
// presence memory and of the ring memory, evaluate judges hit and eviction,
// and commit commits the writes and loads the output register. The split is
// set by the registered read of the presence memory and by its single write
// port, which a miss with eviction uses twice. Sequences are cleared by
// advancing an epoch tag; after reset, and after every 255th sequence, a
// clearing pass over all 1024 words sweeps the presence memory while the
// input is stalled. Capacity may be written over the APB port at any time.
// ----------------------------------------------------------------------------
module fifo_cache_miss_counter #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fcmc_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fcmc_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcmc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fcmc_pkg::PDATA_BITS-1:0] pwdata,
  output logic [fcmc_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);

  import fcmc_pkg::*;

  localparam int unsigned IDX_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_BITS = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_BITS  = FILL_BITS + 1;
  localparam int unsigned CMP_BITS  = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;
  localparam int unsigned CAP_RESET = (RING_DEPTH > 255) ? 255 : RING_DEPTH;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_EVAL   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CAP_BITS-1:0]  capacity_q, capacity_d;
  logic [IDX_BITS-1:0]  oldest_q, oldest_d;
  logic [FILL_BITS-1:0] fill_q, fill_d;
  logic [MISS_BITS-1:0] misses_q, misses_d;
  epoch_t               epoch_q, epoch_d;
  word_t                clr_q, clr_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_data_q, out_data_d;

  word_t                word_q;
  logic                 last_q;
  logic                 hit_q;
  logic                 evict_q;
  word_t                ev_word_q;

  logic                 in_accept;
  logic                 cfg_write;
  logic                 commit_fire;
  logic                 hit_d;
  logic                 evict_d;
  logic [CMP_BITS-1:0]  cap_ext;
  logic [CMP_BITS-1:0]  eff_cap;
  logic [SUM_BITS-1:0]  ins_sum;
  logic [IDX_BITS-1:0]  ins_idx;
  logic [MISS_BITS-1:0] misses_inc;

  logic                 pres_we;
  word_t                pres_waddr;
  epoch_t               pres_wdata;
  epoch_t               pres_rdata;
  logic                 ring_we;
  word_t                ring_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    capacity_d = capacity_q;
    if (cfg_write && (paddr[2:2] == REG_CAPACITY)) begin
      capacity_d = pwdata[CAP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == REG_CAPACITY) begin
      prdata = PDATA_BITS'(capacity_q);
    end
  end

  // Memories: the ring holds cached words in FIFO order, the presence memory
  // holds per word the epoch of the sequence that cached it.
  fcmc_sdp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ins_idx),
    .wdata_i (word_q),
    .re_i    (in_accept),
    .raddr_i (oldest_q),
    .rdata_o (ring_rdata)
  );

  fcmc_sdp_ram #(
    .WIDTH (EPOCH_BITS),
    .DEPTH (WORD_COUNT)
  ) u_presence (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .waddr_i (pres_waddr),
    .wdata_i (pres_wdata),
    .re_i    (in_accept),
    .raddr_i (in_data_i.word),
    .rdata_o (pres_rdata)
  );

  // Lookup evaluation.
  always_comb begin
    cap_ext = CMP_BITS'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(RING_DEPTH)) begin
      eff_cap = CMP_BITS'(RING_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    hit_d   = (pres_rdata == epoch_q);
    evict_d = !hit_d && (CMP_BITS'(fill_q) >= eff_cap) && (fill_q != '0);
  end

  // Insert position is oldest plus fill, with or without an eviction.
  always_comb begin
    ins_sum = SUM_BITS'(oldest_q) + SUM_BITS'(fill_q);
    if (ins_sum >= SUM_BITS'(RING_DEPTH)) begin
      ins_sum = ins_sum - SUM_BITS'(RING_DEPTH);
    end
    ins_idx = ins_sum[IDX_BITS-1:0];
  end

  assign misses_inc = (misses_q == '1) ? misses_q : misses_q + 1'b1;
  assign ring_we    = commit_fire && !hit_q;

  always_comb begin
    pres_we    = 1'b0;
    pres_waddr = word_q;
    pres_wdata = epoch_q;
    unique case (state_q)
      ST_CLEAR: begin
        pres_we    = 1'b1;
        pres_waddr = clr_q;
        pres_wdata = '0;
      end
      ST_EVAL: begin
        // The evicted word is dropped here so that the insert can follow.
        pres_we    = evict_d;
        pres_waddr = ring_rdata;
        pres_wdata = '0;
      end
      ST_COMMIT: begin
        pres_we = commit_fire && !hit_q;
      end
      default: begin
        pres_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    misses_d    = misses_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == word_t'(WORD_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_fire) begin
          out_valid_d              = 1'b1;
          out_data_d.hit           = hit_q;
          out_data_d.evicted_valid = evict_q;
          out_data_d.evicted_word  = ev_word_q;
          out_data_d.miss_count    = hit_q ? misses_q : misses_inc;
          out_data_d.done_res      = last_q;
          state_d                  = ST_IDLE;
          if (!hit_q) begin
            misses_d = misses_inc;
            if (evict_q) begin
              oldest_d = (oldest_q == IDX_BITS'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
            end else begin
              fill_d = fill_q + 1'b1;
            end
          end
          if (last_q) begin
            oldest_d = '0;
            fill_d   = '0;
            misses_d = '0;
            // Epoch zero marks an absent word, so a wrap needs a full sweep.
            if (epoch_q == '1) begin
              epoch_d = epoch_t'(1);
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      capacity_q  <= CAP_BITS'(CAP_RESET);
      oldest_q    <= '0;
      fill_q      <= '0;
      misses_q    <= '0;
      epoch_q     <= epoch_t'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      capacity_q  <= capacity_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      misses_q    <= misses_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_accept) begin
      word_q <= in_data_i.word;
      last_q <= in_data_i.last;
    end
    if (state_q == ST_EVAL) begin
      hit_q     <= hit_d;
      evict_q   <= evict_d;
      ev_word_q <= evict_d ? ring_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/fcmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO cache miss counter checker
// Port-level properties of the cache block, bound to the top level.
// ----------------------------------------------------------------------------
module fcmc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input fcmc_pkg::out_t out_data_o
);

  import fcmc_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A hit never evicts, and an eviction is always a counted miss.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted_valid |-> !out_data_o.hit &&
      (out_data_o.miss_count != '0))
    else $error("eviction reported on a hit or with zero misses");

  // Without an eviction the reported word is zero.
  a_evict_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.evicted_valid |-> out_data_o.evicted_word == '0)
    else $error("evicted word set without an eviction");

  // The presence memory is swept after reset before any word is taken.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken before the clearing pass");

endmodule

bind fifo_cache_miss_counter fcmc_checker u_fcmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO cache miss counter testbench
// Drives word lookups through the valid/stall input channel with bursty
// traffic and a stalling receiver. A predictor of the FIFO cache keeps its own
// ring, presence map and miss counter, and every result is checked field by
// field. Capacity is changed over APB between phases, also mid-sequence.
// ----------------------------------------------------------------------------
module tb_top;
  import fcmc_pkg::*;

  localparam int unsigned RING_DEPTH   = 128;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS   = 1_000_000;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned PHASE_ITEMS  = 20;
  localparam int unsigned SINGLE_SEQS  = 260;
  localparam logic [PADDR_BITS-1:0] CAP_ADDR = PADDR_BITS'(4 * REG_CAPACITY);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_BITS-1:0] paddr       = '0;
  logic [PDATA_BITS-1:0] pwdata      = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  fifo_cache_miss_counter #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Lookup queues and run statistics.
  in_t         pending_words_q[$];
  out_t        expected_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned lookup_total   = 0;
  int unsigned hit_total      = 0;
  int unsigned evict_total    = 0;
  int unsigned seq_total      = 0;

  // Predicted cache state.
  word_t                cache_ring[RING_DEPTH];
  bit                   cache_present[WORD_COUNT];
  int unsigned          cache_oldest   = 0;
  int unsigned          cache_fill     = 0;
  logic [MISS_BITS-1:0] cache_misses   = '0;
  logic [CAP_BITS-1:0]  cache_capacity = CAP_BITS'(RING_DEPTH);

  // Traffic shaping state.
  logic        in_taken   = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        stall_on   = 1'b0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("tb: mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got,
               want);
    end
  endtask

  function automatic int unsigned eff_capacity();
    if (cache_capacity == 0) return 1;
    if (cache_capacity > RING_DEPTH) return RING_DEPTH;
    return cache_capacity;
  endfunction

  task automatic predict_lookup(input in_t item);
    out_t res;
    res          = '0;
    res.done_res = item.last;
    lookup_total++;
    if (cache_present[item.word]) begin
      res.hit = 1'b1;
      hit_total++;
    end else begin
      // A lowered capacity still evicts only one entry per miss.
      if (cache_fill >= eff_capacity() && cache_fill > 0) begin
        res.evicted_valid = 1'b1;
        res.evicted_word  = cache_ring[cache_oldest];
        cache_present[res.evicted_word] = 1'b0;
        cache_oldest = (cache_oldest + 1) % RING_DEPTH;
        cache_fill--;
        evict_total++;
      end
      cache_ring[(cache_oldest + cache_fill) % RING_DEPTH] = item.word;
      cache_present[item.word] = 1'b1;
      cache_fill++;
      if (cache_misses != '1) cache_misses++;
    end
    res.miss_count = cache_misses;
    if (item.last) begin
      foreach (cache_present[i]) cache_present[i] = 1'b0;
      cache_oldest = 0;
      cache_fill   = 0;
      cache_misses = '0;
      seq_total++;
    end
    expected_results_q.push_back(res);
  endtask

  // Monitor: predicts on every accepted lookup and checks every accepted result.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) predict_lookup(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data_o, 0);
        end else begin
          want = expected_results_q.pop_front();
          if (out_data_o.hit !== want.hit)
            report_mismatch("hit", out_data_o.hit, want.hit);
          if (out_data_o.evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", out_data_o.evicted_valid, want.evicted_valid);
          if (out_data_o.evicted_word !== want.evicted_word)
            report_mismatch("evicted_word", out_data_o.evicted_word, want.evicted_word);
          if (out_data_o.miss_count !== want.miss_count)
            report_mismatch("miss_count", out_data_o.miss_count, want.miss_count);
          if (out_data_o.done_res !== want.done_res)
            report_mismatch("done_res", out_data_o.done_res, want.done_res);
        end
      end
    end
  end

  // Driver: bursts of lookups with random gaps, and a receiver stall pattern.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words_q.size() > 0) begin
          in_data_i  <= pending_words_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_on   = !stall_on && ($urandom_range(0, 2) != 0);
        stall_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 40);
      end
      out_stall_i <= stall_on;
    end
  end

  task automatic apb_transfer(input logic wr, input logic [PDATA_BITS-1:0] data,
                              output logic [PDATA_BITS-1:0] rd);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAP_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_capacity();
    logic [PDATA_BITS-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd[CAP_BITS-1:0] !== cache_capacity)
      report_mismatch("capacity readback", rd, cache_capacity);
  endtask

  task automatic set_capacity(input int unsigned value);
    logic [PDATA_BITS-1:0] rd;
    apb_transfer(1'b1, PDATA_BITS'(value), rd);
    cache_capacity = CAP_BITS'(value);
    check_capacity();
  endtask

  task automatic wait_drained();
    while (pending_words_q.size() != 0 || in_valid_i || expected_results_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_word(input int unsigned w, input bit last);
    in_t item;
    item.word = word_t'(w);
    item.last = last;
    pending_words_q.push_back(item);
  endtask

  // Words are drawn from a window around the capacity so hits and evictions
  // both happen often; a tenth of them are random noise.
  task automatic queue_sequence(input int unsigned len, input bit closed);
    word_t       base;
    word_t       w;
    int unsigned pool;
    pool = $urandom_range(1, 2 * eff_capacity() + 4);
    base = word_t'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) w = word_t'($urandom);
      else w = base + word_t'($urandom_range(0, pool - 1));
      queue_word(w, closed && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned cap_plan[10] = '{1, 128, 255, 0, 3, 64, 17, 2, 128, 200};
    int unsigned phase_items;
    int unsigned len;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_capacity();

    // Directed: extremes of the word, hits, evictions in order, one-word
    // sequence, and capacity lowered to 1 and 0 then raised to 255 mid-sequence.
    set_capacity(2);
    queue_word(0, 0);
    queue_word(1023, 0);
    queue_word(0, 0);
    queue_word(512, 0);
    queue_word(0, 0);
    queue_word(1023, 0);
    queue_word(341, 0);
    queue_word(682, 1);
    queue_word(7, 1);
    wait_drained();
    set_capacity(4);
    for (int unsigned w = 10; w < 14; w++) queue_word(w, 0);
    wait_drained();
    set_capacity(1);
    queue_word(14, 0);
    queue_word(13, 0);
    queue_word(15, 0);
    wait_drained();
    set_capacity(0);
    queue_word(16, 0);
    queue_word(16, 0);
    wait_drained();
    set_capacity(255);
    queue_word(17, 0);
    queue_word(18, 0);
    queue_word(13, 1);
    wait_drained();

    // Random phases; the last sequence of a phase may stay open across the
    // capacity change. Each phase drains completely before the next write.
    foreach (cap_plan[p]) begin
      set_capacity(cap_plan[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 30);
        queue_sequence(len, (phase_items + len < PHASE_ITEMS) || ($urandom_range(0, 1) == 1));
        phase_items += len;
      end
      wait_drained();
    end

    // Many one-word sequences force the block through its periodic clearing
    // pass; longer sequences afterwards check that the map really was cleared.
    for (int unsigned i = 0; i < SINGLE_SEQS; i++) queue_word($urandom, 1);
    queue_sequence(40, 1);
    queue_sequence(30, 1);
    wait_drained();

    $display("tb: %0d lookups in %0d sequences, %0d hits, %0d evictions checked",
             lookup_total, seq_total, hit_total, evict_total);
    $display("tb: capacity went through 0, 1, 2, 128 and 255, lowered and raised mid-sequence");
    if (mismatch_count == 0 && expected_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: timeout with %0d results outstanding", expected_results_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
src/fcmc_pkg.sv
src/fcmc_sdp_ram.sv
src/fifo_cache_miss_counter.sv
src/fcmc_checker.sv
sim/tb_top.sv
